/* sv/mos6502_subset_execute_unit_assert.svh */
// Assertion macros for the execute unit.
`ifndef MOS6502_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define MOS6502_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define M65_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define M65_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* sv/m65_pkg.sv */
// ----------------------------------------------------------------------------
// m65_pkg
// Types, codes and constants shared by the 6502 subset execute unit.
// ----------------------------------------------------------------------------
package m65_pkg;

    localparam int NUM_PAGES_DEF = 256;
    localparam int PAGE_BYTES    = 256;

    // commands
    localparam logic [4:0] CMD_LDA = 5'd0;
    localparam logic [4:0] CMD_LDX = 5'd1;
    localparam logic [4:0] CMD_LDY = 5'd2;
    localparam logic [4:0] CMD_STA = 5'd3;
    localparam logic [4:0] CMD_STX = 5'd4;
    localparam logic [4:0] CMD_STY = 5'd5;
    localparam logic [4:0] CMD_TAX = 5'd6;
    localparam logic [4:0] CMD_TAY = 5'd7;
    localparam logic [4:0] CMD_TXA = 5'd8;
    localparam logic [4:0] CMD_TYA = 5'd9;
    localparam logic [4:0] CMD_CLC = 5'd10;
    localparam logic [4:0] CMD_CLD = 5'd11;
    localparam logic [4:0] CMD_CLI = 5'd12;
    localparam logic [4:0] CMD_CLV = 5'd13;
    localparam logic [4:0] CMD_SEC = 5'd14;
    localparam logic [4:0] CMD_SED = 5'd15;
    localparam logic [4:0] CMD_SEI = 5'd16;
    localparam logic [4:0] CMD_ADC = 5'd17;
    localparam logic [4:0] CMD_SBC = 5'd18;
    localparam logic [4:0] CMD_CMP = 5'd19;
    localparam logic [4:0] CMD_CPX = 5'd20;
    localparam logic [4:0] CMD_CPY = 5'd21;
    localparam logic [4:0] CMD_BRK = 5'd22;
    localparam logic [4:0] CMD_MLD = 5'd23;

    // addressing modes
    localparam logic [3:0] AM_IMM  = 4'd2;
    localparam logic [3:0] AM_ZP   = 4'd3;
    localparam logic [3:0] AM_ZPX  = 4'd4;
    localparam logic [3:0] AM_ABS  = 4'd7;
    localparam logic [3:0] AM_ABSX = 4'd8;
    localparam logic [3:0] AM_ABSY = 4'd9;
    localparam logic [3:0] AM_INDX = 4'd11;
    localparam logic [3:0] AM_INDY = 4'd12;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_CMD   = 2'd1;
    localparam logic [1:0] ERR_MODE  = 2'd2;
    localparam logic [1:0] ERR_STACK = 2'd3;

    // status flags
    localparam logic [7:0] FLAG_N = 8'h80;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_D = 8'h08;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_C = 8'h01;

    localparam logic [7:0]  STATUS_RESET = 8'h20;
    localparam logic [7:0]  STACK_PAGE   = 8'h01;
    localparam logic [7:0]  STACK_MAX    = 8'd252;
    localparam logic [15:0] VEC_LO_ADDR  = 16'hFFFE;
    localparam logic [15:0] VEC_HI_ADDR  = 16'hFFFF;

    typedef struct packed {
        logic [4:0]  command;
        logic [3:0]  address_mode;
        logic [15:0] operand_value;
        logic [7:0]  load_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  status_out;
        logic [15:0] pc_out;
        logic [7:0]  stack_depth_out;
        logic        mem_write;
        logic [15:0] mem_write_addr;
        logic [7:0]  mem_write_data;
        logic [1:0]  error_code;
    } t_out_word;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic        cin;
    } t_alu_req;

endpackage

/* sv/mos6502_subset_execute_unit.sv */
// ----------------------------------------------------------------------------
// mos6502_subset_execute_unit
// Executes one predecoded 6502 instruction per word against A, X, Y, P, PC,
// stack depth and a byte memory.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  input   | i_in_valid   | o_in_stall   | i_in_word  (t_in_word)
//  output  | o_out_valid  | i_out_stall  | o_out_word (t_out_word)
//
// One word at a time; each word steps through the states in turn, sharing
// the single memory port and the shared adder. After reset a clearing pass
// zeroes memory, input stalled. The result holds on o_out_word until taken;
// input stays stalled.
// ----------------------------------------------------------------------------
module mos6502_subset_execute_unit
    import m65_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    `include "mos6502_subset_execute_unit_assert.svh"

    localparam logic [15:0] CLR_LAST = 16'(NUM_PAGES * PAGE_BYTES - 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_PTR_LO, S_PTR_HI, S_PTR_WAIT, S_INDEX,
        S_READ, S_RWAIT, S_EXEC, S_STORE, S_BRK_HI, S_BRK_LO, S_BRK_ST,
        S_VEC_LO, S_VEC_HI, S_VEC_WAIT, S_OUT
    } t_state;

    t_state      r_state;
    logic [4:0]  r_cmd;
    logic [3:0]  r_mode;
    logic [15:0] r_opv;
    logic [7:0]  r_ld;
    logic [7:0]  r_acc, r_x, r_y, r_p, r_sp;
    logic [15:0] r_pc, r_ea, r_waddr;
    logic [7:0]  r_ptr, r_lo, r_m, r_wdata;
    logic        r_wr;
    logic [1:0]  r_err;
    logic [15:0] r_clr;

    t_alu_req    alu_req;
    logic [16:0] alu_sum;
    logic        mem_we;
    logic [15:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;

    logic        is_read, is_store, zp_mode;
    logic [1:0]  d_err;
    logic [7:0]  ex_a, ex_b, st_val;
    logic        ex_cin;

    m65_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    m65_mem #(.NUM_PAGES(NUM_PAGES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    function automatic logic [7:0] f_zn(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p & ~(FLAG_Z | FLAG_N);
        if (v == 8'd0) q = q | FLAG_Z;
        q = q | (v & FLAG_N);
        return q;
    endfunction

    // decode checks
    always_comb begin
        is_read  = (r_cmd inside {[CMD_LDA:CMD_LDY], [CMD_ADC:CMD_CPY]});
        is_store = (r_cmd inside {[CMD_STA:CMD_STY]});
        zp_mode  = (r_mode inside {AM_ZP, AM_ZPX, AM_INDX, AM_INDY});
        d_err    = ERR_OK;
        if (r_cmd > CMD_MLD) begin
            d_err = ERR_CMD;
        end else if (is_read || is_store) begin
            if (!(r_mode inside {AM_ZP, AM_ZPX, AM_ABS, AM_ABSX, AM_ABSY,
                                 AM_INDX, AM_INDY})
                && !(is_read && r_mode == AM_IMM)) begin
                d_err = ERR_MODE;
            end else if (zp_mode && r_opv[15:8] != 8'd0) begin
                d_err = ERR_MODE;
            end
        end else if (r_cmd == CMD_BRK && r_sp > STACK_MAX) begin
            d_err = ERR_STACK;
        end
    end

    // operand selection for the execute step
    always_comb begin
        case (r_cmd)
            CMD_CPX: ex_a = r_x;
            CMD_CPY: ex_a = r_y;
            default: ex_a = r_acc;
        endcase
        ex_b   = (r_cmd == CMD_ADC) ? r_m : ~r_m;
        ex_cin = (r_cmd inside {CMD_ADC, CMD_SBC}) ? r_p[0] : 1'b1;
        case (r_cmd)
            CMD_STX: st_val = r_x;
            CMD_STY: st_val = r_y;
            default: st_val = r_acc;
        endcase
    end

    // shared adder requests
    always_comb begin
        alu_req = '0;
        case (r_state)
            S_DECODE: begin
                alu_req.a = r_opv;
                if (r_mode inside {AM_ZPX, AM_ABSX, AM_INDX}) begin
                    alu_req.b = {8'd0, r_x};
                end else if (r_mode == AM_ABSY) begin
                    alu_req.b = {8'd0, r_y};
                end
            end
            S_PTR_HI: begin
                alu_req.a   = {8'd0, r_ptr};
                alu_req.cin = 1'b1;
            end
            S_INDEX: begin
                alu_req.a = r_ea;
                alu_req.b = {8'd0, r_y};
            end
            S_EXEC: begin
                alu_req.a   = {8'd0, ex_a};
                alu_req.b   = {8'd0, ex_b};
                alu_req.cin = ex_cin;
            end
            S_BRK_LO: begin
                alu_req.a   = {8'd0, r_sp};
                alu_req.cin = 1'b1;
            end
            S_BRK_ST: begin
                alu_req.a   = {8'd0, r_sp};
                alu_req.b   = 16'd1;
                alu_req.cin = 1'b1;
            end
            S_VEC_LO: begin
                alu_req.a   = {8'd0, r_sp};
                alu_req.b   = 16'd2;
                alu_req.cin = 1'b1;
            end
            default: alu_req = '0;
        endcase
    end

    // memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ea;
        mem_wdata = 8'd0;
        mem_raddr = r_ea;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_DECODE: begin
                mem_we    = (r_cmd == CMD_MLD);
                mem_waddr = r_opv;
                mem_wdata = r_ld;
            end
            S_STORE: begin
                mem_we    = 1'b1;
                mem_wdata = st_val;
            end
            S_BRK_HI: begin
                mem_we    = 1'b1;
                mem_waddr = {STACK_PAGE, r_sp};
                mem_wdata = r_pc[15:8];
            end
            S_BRK_LO: begin
                mem_we    = 1'b1;
                mem_waddr = {STACK_PAGE, alu_sum[7:0]};
                mem_wdata = r_pc[7:0];
            end
            S_BRK_ST: begin
                mem_we    = 1'b1;
                mem_waddr = {STACK_PAGE, alu_sum[7:0]};
                mem_wdata = r_p;
            end
            S_PTR_LO: mem_raddr = {8'd0, r_ptr};
            S_PTR_HI: mem_raddr = {8'd0, alu_sum[7:0]};
            S_VEC_LO: mem_raddr = VEC_LO_ADDR;
            S_VEC_HI: mem_raddr = VEC_HI_ADDR;
            default: mem_raddr = r_ea;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= 16'd0;
            r_acc   <= 8'd0;
            r_x     <= 8'd0;
            r_y     <= 8'd0;
            r_p     <= STATUS_RESET;
            r_pc    <= 16'd0;
            r_sp    <= 8'd0;
            r_wr    <= 1'b0;
            r_waddr <= 16'd0;
            r_wdata <= 8'd0;
            r_err   <= ERR_OK;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 16'd1;
                    if (r_clr == CLR_LAST) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_word.command;
                        r_mode  <= i_in_word.address_mode;
                        r_opv   <= i_in_word.operand_value;
                        r_ld    <= i_in_word.load_data;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_wr    <= 1'b0;
                    r_waddr <= 16'd0;
                    r_wdata <= 8'd0;
                    r_err   <= d_err;
                    r_state <= S_OUT;
                    if (d_err == ERR_OK) begin
                        if (is_read || is_store) begin
                            case (r_mode)
                                AM_IMM: begin
                                    r_m     <= r_opv[7:0];
                                    r_state <= S_EXEC;
                                end
                                AM_ZPX: begin
                                    r_ea    <= {8'd0, alu_sum[7:0]};
                                    r_state <= is_store ? S_STORE : S_READ;
                                end
                                AM_ABSX, AM_ABSY: begin
                                    r_ea    <= alu_sum[15:0];
                                    r_state <= is_store ? S_STORE : S_READ;
                                end
                                AM_INDX: begin
                                    r_ptr   <= alu_sum[7:0];
                                    r_state <= S_PTR_LO;
                                end
                                AM_INDY: begin
                                    r_ptr   <= r_opv[7:0];
                                    r_state <= S_PTR_LO;
                                end
                                default: begin
                                    r_ea    <= r_opv;
                                    r_state <= is_store ? S_STORE : S_READ;
                                end
                            endcase
                        end else begin
                            case (r_cmd)
                                CMD_TAX: begin r_x <= r_acc; r_p <= f_zn(r_p, r_acc); end
                                CMD_TAY: begin r_y <= r_acc; r_p <= f_zn(r_p, r_acc); end
                                CMD_TXA: begin r_acc <= r_x; r_p <= f_zn(r_p, r_x); end
                                CMD_TYA: begin r_acc <= r_y; r_p <= f_zn(r_p, r_y); end
                                CMD_CLC: r_p <= r_p & ~FLAG_C;
                                CMD_CLD: r_p <= r_p & ~FLAG_D;
                                CMD_CLI: r_p <= r_p & ~FLAG_I;
                                CMD_CLV: r_p <= r_p & ~FLAG_V;
                                CMD_SEC: r_p <= r_p | FLAG_C;
                                CMD_SED: r_p <= r_p | FLAG_D;
                                CMD_SEI: r_p <= r_p | FLAG_I;
                                CMD_BRK: begin
                                    r_p     <= r_p | FLAG_B;
                                    r_state <= S_BRK_HI;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_PTR_LO: r_state <= S_PTR_HI;
                S_PTR_HI: begin
                    r_lo    <= mem_rdata;
                    r_state <= S_PTR_WAIT;
                end
                S_PTR_WAIT: begin
                    r_ea <= {mem_rdata, r_lo};
                    if (r_mode == AM_INDY) begin
                        r_state <= S_INDEX;
                    end else begin
                        r_state <= is_store ? S_STORE : S_READ;
                    end
                end
                S_INDEX: begin
                    r_ea    <= alu_sum[15:0];
                    r_state <= is_store ? S_STORE : S_READ;
                end
                S_READ: r_state <= S_RWAIT;
                S_RWAIT: begin
                    r_m     <= mem_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    case (r_cmd)
                        CMD_LDA: begin r_acc <= r_m; r_p <= f_zn(r_p, r_m); end
                        CMD_LDX: begin r_x <= r_m; r_p <= f_zn(r_p, r_m); end
                        CMD_LDY: begin r_y <= r_m; r_p <= f_zn(r_p, r_m); end
                        CMD_ADC, CMD_SBC: begin
                            r_acc <= alu_sum[7:0];
                            r_p   <= (f_zn(r_p, alu_sum[7:0]) & ~(FLAG_C | FLAG_V))
                                   | (alu_sum[8] ? FLAG_C : 8'd0)
                                   | ((~(ex_a[7] ^ ex_b[7]) & (ex_a[7] ^ alu_sum[7]))
                                      ? FLAG_V : 8'd0);
                        end
                        default: begin
                            r_p <= (r_p & ~(FLAG_Z | FLAG_C | FLAG_N))
                                 | ((alu_sum[7:0] == 8'd0) ? FLAG_Z : 8'd0)
                                 | (alu_sum[8] ? FLAG_C : 8'd0)
                                 | (alu_sum[7] ? FLAG_N : 8'd0);
                        end
                    endcase
                end
                S_STORE: begin
                    r_wr    <= 1'b1;
                    r_waddr <= r_ea;
                    r_wdata <= st_val;
                    r_state <= S_OUT;
                end
                S_BRK_HI: r_state <= S_BRK_LO;
                S_BRK_LO: r_state <= S_BRK_ST;
                S_BRK_ST: r_state <= S_VEC_LO;
                S_VEC_LO: begin
                    r_sp    <= alu_sum[7:0];
                    r_state <= S_VEC_HI;
                end
                S_VEC_HI: begin
                    r_lo    <= mem_rdata;
                    r_state <= S_VEC_WAIT;
                end
                S_VEC_WAIT: begin
                    r_pc    <= {mem_rdata, r_lo};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_out_word.acc_out         = r_acc;
        o_out_word.x_out           = r_x;
        o_out_word.y_out           = r_y;
        o_out_word.status_out      = r_p;
        o_out_word.pc_out          = r_pc;
        o_out_word.stack_depth_out = r_sp;
        o_out_word.mem_write       = r_wr;
        o_out_word.mem_write_addr  = r_waddr;
        o_out_word.mem_write_data  = r_wdata;
        o_out_word.error_code      = r_err;
    end

    `M65_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall,
        "result pending while input open")
    `M65_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall && !o_out_valid, "accepted word not held in decode")
    `M65_ASSERT_NOW(a_write_no_err, i_clk, i_rst_n, o_out_valid && o_out_word.mem_write,
        o_out_word.error_code == ERR_OK, "store reported with error")
    `M65_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR,
        !o_out_valid && o_in_stall, "activity during clearing pass")

endmodule

/* sv/m65_alu.sv */
// ----------------------------------------------------------------------------
// m65_alu
// Shared 16-bit adder: address indexing, pointer and stack steps, ADC/SBC/CMP.
// ----------------------------------------------------------------------------
module m65_alu
    import m65_pkg::*;
(
    input  t_alu_req    i_req,
    output logic [16:0] o_sum
);

    assign o_sum = {1'b0, i_req.a} + {1'b0, i_req.b} + {16'd0, i_req.cin};

endmodule

/* sv/m65_mem.sv */
// ----------------------------------------------------------------------------
// m65_mem
// Byte memory, one write and one registered read port; page folded modulo
// the number of pages.
// ----------------------------------------------------------------------------
module m65_mem
    import m65_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [15:0] i_waddr,
    input  logic [7:0]  i_wdata,
    input  logic [15:0] i_raddr,
    output logic [7:0]  o_rdata
);

    localparam int DEPTH = NUM_PAGES * PAGE_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW - 8;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // restoring reduction of the page number, one constant multiple per step
    function automatic logic [AW-1:0] f_index(input logic [15:0] a);
        logic [7:0] r;
        r = a[15:8];
        for (int k = 7; k >= 0; k--) begin
            if ((NUM_PAGES << k) <= 255) begin
                if (r >= 8'(NUM_PAGES << k)) begin
                    r = r - 8'(NUM_PAGES << k);
                end
            end
        end
        return {r[PW-1:0], a[7:0]};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[f_index(i_waddr)] <= i_wdata;
        end
        r_rdata <= r_mem[f_index(i_raddr)];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/mos6502_subset_execute_unit_tb.sv */
// ----------------------------------------------------------------------------
// mos6502_subset_execute_unit_tb
// Self-checking bench: a directed table then random instruction streams are
// run through the unit, and each result word is compared with a local model or a fixed expectation.
// ----------------------------------------------------------------------------
module mos6502_subset_execute_unit_tb
    import m65_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AM_REL  = 6;
    localparam int N_RANDOM = 1730;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    mos6502_subset_execute_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word)
    );

    // model state
    logic [7:0]  cpu_mem [0:65535];
    logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_p, cpu_sp;
    logic [15:0] cpu_pc;

    t_out_word exp_words[$];
    logic      exp_fixed[$];
    t_out_word fixed_words[$];
    int  n_fail = 0;
    int  n_checked = 0;
    int  n_sent = 0;
    int  n_brk = 0;
    bit  quiet = 0;
    bit  hold_rx = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] with_zn(logic [7:0] p, logic [7:0] v);
        with_zn = (p & ~(FLAG_Z | FLAG_N)) | (v == 0 ? FLAG_Z : 8'h00) | (v & FLAG_N);
    endfunction

    // effective address; returns 1 on a legal mode
    function automatic bit eff_addr(logic [3:0] md, logic [15:0] opv,
                                    output logic [15:0] ea);
        logic [7:0] p;
        logic [15:0] ptr;
        ea = 0;
        if ((md == AM_ZP || md == AM_ZPX || md == AM_INDX || md == AM_INDY) && opv > 16'hFF)
            return 0;
        case (md)
            AM_ZP, AM_ABS: ea = opv;
            AM_ZPX: ea = {8'h00, opv[7:0] + cpu_x};
            AM_ABSX: ea = opv + cpu_x;
            AM_ABSY: ea = opv + cpu_y;
            AM_INDX: begin
                p = opv[7:0] + cpu_x;
                ea = {cpu_mem[{8'h00, p + 8'd1}], cpu_mem[{8'h00, p}]};
            end
            AM_INDY: begin
                ptr = {cpu_mem[{8'h00, opv[7:0] + 8'd1}], cpu_mem[opv]};
                ea = ptr + cpu_y;
            end
            default: return 0;
        endcase
        return 1;
    endfunction

    function automatic void adder(logic [7:0] m);
        logic [8:0] raw;
        logic [7:0] r;
        raw = cpu_a + m + cpu_p[0];
        r = raw[7:0];
        cpu_p = cpu_p & ~(FLAG_C | FLAG_V);
        if (raw[8]) cpu_p |= FLAG_C;
        if (~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ r[7])) cpu_p |= FLAG_V;
        cpu_a = r;
        cpu_p = with_zn(cpu_p, r);
    endfunction

    function automatic void comparer(logic [7:0] r, logic [7:0] m);
        logic [7:0] d;
        d = r - m;
        cpu_p = cpu_p & ~(FLAG_Z | FLAG_C | FLAG_N);
        if (r == m) cpu_p |= FLAG_Z;
        if (r >= m) cpu_p |= FLAG_C;
        cpu_p |= d & FLAG_N;
    endfunction

    function automatic t_out_word execute(t_in_word w);
        t_out_word o;
        logic [15:0] ea;
        logic [7:0]  m, v;
        logic [4:0]  c;
        logic [1:0]  err;
        bit ok;
        o = '0;
        err = ERR_OK;
        c = w.command;
        if (c <= CMD_LDY || (c >= CMD_ADC && c <= CMD_CPY)) begin
            ok = 1;
            if (w.address_mode == AM_IMM) m = w.operand_value[7:0];
            else begin
                ok = eff_addr(w.address_mode, w.operand_value, ea);
                m = cpu_mem[ea];
            end
            if (!ok) err = ERR_MODE;
            else case (c)
                CMD_LDA: begin cpu_a = m; cpu_p = with_zn(cpu_p, m); end
                CMD_LDX: begin cpu_x = m; cpu_p = with_zn(cpu_p, m); end
                CMD_LDY: begin cpu_y = m; cpu_p = with_zn(cpu_p, m); end
                CMD_ADC: adder(m);
                CMD_SBC: adder(~m);
                CMD_CMP: comparer(cpu_a, m);
                CMD_CPX: comparer(cpu_x, m);
                default: comparer(cpu_y, m);
            endcase
        end else if (c >= CMD_STA && c <= CMD_STY) begin
            if (!eff_addr(w.address_mode, w.operand_value, ea)) err = ERR_MODE;
            else begin
                v = (c == CMD_STA) ? cpu_a : (c == CMD_STX) ? cpu_x : cpu_y;
                cpu_mem[ea] = v;
                o.mem_write = 1;
                o.mem_write_addr = ea;
                o.mem_write_data = v;
            end
        end else begin
            case (c)
                CMD_TAX: begin cpu_x = cpu_a; cpu_p = with_zn(cpu_p, cpu_x); end
                CMD_TAY: begin cpu_y = cpu_a; cpu_p = with_zn(cpu_p, cpu_y); end
                CMD_TXA: begin cpu_a = cpu_x; cpu_p = with_zn(cpu_p, cpu_a); end
                CMD_TYA: begin cpu_a = cpu_y; cpu_p = with_zn(cpu_p, cpu_a); end
                CMD_CLC: cpu_p &= ~FLAG_C;
                CMD_CLD: cpu_p &= ~FLAG_D;
                CMD_CLI: cpu_p &= ~FLAG_I;
                CMD_CLV: cpu_p &= ~FLAG_V;
                CMD_SEC: cpu_p |= FLAG_C;
                CMD_SED: cpu_p |= FLAG_D;
                CMD_SEI: cpu_p |= FLAG_I;
                CMD_BRK: begin
                    if (cpu_sp > STACK_MAX) err = ERR_STACK;
                    else begin
                        cpu_p |= FLAG_B;
                        cpu_mem[{STACK_PAGE, cpu_sp}] = cpu_pc[15:8];
                        cpu_mem[{STACK_PAGE, 8'(cpu_sp + 1)}] = cpu_pc[7:0];
                        cpu_mem[{STACK_PAGE, 8'(cpu_sp + 2)}] = cpu_p;
                        cpu_sp = cpu_sp + 3;
                        cpu_pc = {cpu_mem[VEC_HI_ADDR], cpu_mem[VEC_LO_ADDR]};
                    end
                end
                CMD_MLD: cpu_mem[w.operand_value] = w.load_data;
                default: err = ERR_CMD;
            endcase
        end
        o.acc_out = cpu_a;
        o.x_out = cpu_x;
        o.y_out = cpu_y;
        o.status_out = cpu_p;
        o.pc_out = cpu_pc;
        o.stack_depth_out = cpu_sp;
        o.error_code = err;
        return o;
    endfunction

    // sender: one word, with random gaps unless quiet; valid drops only in a gap
    task automatic send(t_in_word w, bit fixed, t_out_word fw);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        exp_words.push_back(execute(w));
        exp_fixed.push_back(fixed);
        fixed_words.push_back(fw);
        if (w.command == CMD_BRK) n_brk++;
        i_in_word <= w;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_in_word mk(logic [4:0] c, logic [3:0] md, logic [15:0] opv,
                                    logic [7:0] ld);
        t_in_word w;
        w.command = c;
        w.address_mode = md;
        w.operand_value = opv;
        w.load_data = ld;
        return w;
    endfunction

    function automatic t_out_word fixed_out(logic [7:0] a, logic [7:0] p, logic [1:0] e);
        t_out_word o;
        o = '0;
        o.acc_out = a;
        o.status_out = p;
        o.error_code = e;
        return o;
    endfunction

    // receiver and checker
    always @(posedge i_clk) begin
        t_out_word e;
        bit fx;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_words.size() == 0) begin
                $display("%0t unexpected word %h", $time, o_out_word);
                n_fail++;
            end else begin
                e = exp_words.pop_front();
                fx = exp_fixed.pop_front();
                if (fx) e = fixed_words.pop_front();
                else void'(fixed_words.pop_front());
                if (o_out_word !== e) begin
                    $display("%0t mismatch: expected %h actual %h", $time, e, o_out_word);
                    n_fail++;
                end
                n_checked++;
            end
        end
    end

    // receiver stall bursts; hold_rx gives the long hold-off
    initial begin
        int k;
        i_out_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1;
                for (k = 0; k < 200; k++) @(negedge i_clk);
                hold_rx = 0;
                i_out_stall <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1;
                k = $urandom_range(1, 15);
                repeat (k) @(negedge i_clk);
                i_out_stall <= 0;
            end
        end
    end

    function automatic logic [3:0] rnd_mode();
        int r;
        r = $urandom_range(0, 15);
        if (r < 12) case (r % 8)
            0: return AM_IMM; 1: return AM_ZP; 2: return AM_ZPX; 3: return AM_ABS;
            4: return AM_ABSX; 5: return AM_ABSY; 6: return AM_INDX; default: return AM_INDY;
        endcase
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [15:0] rnd_opv(logic [3:0] md);
        if (md == AM_ZP || md == AM_ZPX || md == AM_INDX || md == AM_INDY) begin
            if ($urandom_range(0, 15) == 0) return 16'($urandom_range(256, 65535));
            return 16'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 511));
        return 16'($urandom);
    endfunction

    initial begin
        t_in_word dir_tab[$];
        logic     dir_fix[$];
        t_out_word dir_exp[$];
        t_in_word w;
        int i, r;
        logic [4:0] c;
        for (i = 0; i < 65536; i++) cpu_mem[i] = 0;
        cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_p = STATUS_RESET; cpu_pc = 0; cpu_sp = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed table; fixed expectations where obvious
        dir_tab = '{mk(5'd31, 4'd0, 16'h0000, 8'h00), mk(CMD_LDA, AM_IMM, 16'hFF80, 8'h00),
                    mk(CMD_LDA, AM_IMM, 16'h0000, 8'h00), mk(CMD_LDA, 4'(AM_REL), 16'h1234, 0),
                    mk(CMD_LDA, AM_ZP, 16'h0100, 8'h00), mk(CMD_MLD, 4'd15, 16'hFFFE, 8'h34),
                    mk(CMD_MLD, 4'd0, 16'hFFFF, 8'h12), mk(CMD_LDX, AM_IMM, 16'h00FF, 0),
                    mk(CMD_LDY, AM_IMM, 16'h0001, 0), mk(CMD_STA, AM_IMM, 16'h0010, 0),
                    mk(CMD_STX, AM_ZPX, 16'h00FF, 0), mk(CMD_STY, AM_ABSY, 16'hFFFF, 0),
                    mk(CMD_MLD, 0, 16'h00FF, 8'h80), mk(CMD_MLD, 0, 16'h0000, 8'hFF),
                    mk(CMD_LDA, AM_INDY, 16'h00FF, 0), mk(CMD_LDA, AM_INDX, 16'h0000, 0),
                    mk(CMD_TAX, 0, 0, 0), mk(CMD_TYA, 0, 0, 0), mk(CMD_TAY, 0, 0, 0),
                    mk(CMD_TXA, 0, 0, 0), mk(CMD_SEC, 0, 0, 0), mk(CMD_ADC, AM_IMM, 16'h7F, 0),
                    mk(CMD_SBC, AM_ABSX, 16'hFFFF, 0), mk(CMD_CMP, AM_ABS, 16'h00FF, 0),
                    mk(CMD_BRK, 0, 0, 0)};
        dir_fix = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_exp = '{fixed_out(0, STATUS_RESET, ERR_CMD),
                    fixed_out(8'h80, STATUS_RESET | FLAG_N, ERR_OK),
                    fixed_out(0, STATUS_RESET | FLAG_Z, ERR_OK),
                    fixed_out(0, STATUS_RESET | FLAG_Z, ERR_MODE),
                    fixed_out(0, STATUS_RESET | FLAG_Z, ERR_MODE)};
        for (i = 0; i < dir_tab.size(); i++)
            send(dir_tab[i], dir_fix[i], i < dir_exp.size() ? dir_exp[i] : t_out_word'('0));
        w = mk(CMD_CPX, AM_IMM, 0, 0); send(w, 0, '0);
        w = mk(CMD_CPY, AM_IMM, 16'hFF, 0); send(w, 0, '0);
        w = mk(CMD_CLC, 0, 0, 0); send(w, 0, '0);
        for (c = CMD_CLD; c <= CMD_SEI; c++) begin
            w = mk(c, 0, 0, 0); send(w, 0, '0);
        end

        // random part; long receiver hold-off in the middle, quiet at the tail
        // BRK is frequent enough that the stack runs full
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 600) hold_rx = 1;
            if (i == N_RANDOM - 200) quiet = 1;
            r = $urandom_range(0, 99);
            if (r < 3) c = 5'($urandom_range(24, 31));
            else if (r < 13) c = CMD_BRK;
            else if (r < 29) c = CMD_MLD;
            else if (r < 37) c = 5'($urandom_range(CMD_TAX, CMD_SEI));
            else c = 5'($urandom_range(CMD_LDA, CMD_CPY));
            if (c >= CMD_TAX && c <= CMD_SEI && $urandom_range(0, 1)) c = 5'($urandom_range(0, 5));
            w.command = c;
            w.address_mode = rnd_mode();
            w.operand_value = rnd_opv(w.address_mode);
            w.load_data = 8'($urandom);
            if (c == CMD_MLD) begin
                w.address_mode = 4'($urandom);
                if ($urandom_range(0, 3) == 0)
                    w.operand_value = 16'($urandom_range(16'hFFFE, 16'hFFFF));
                else
                    w.operand_value = 16'($urandom_range(0, 511));
            end
            send(w, 0, '0);
        end
        i_in_valid <= 0;

        while (exp_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d words sent, %0d results checked, %0d BRK words incl. stack overflow",
                 n_sent, n_checked, n_brk);
        $display("all commands, modes, error cases and a long output hold-off exercised");
        if (n_fail == 0 && exp_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
